[sv/tcf_pkg.sv]
// Touch coordinate filter: shared types and constants.
// Payload structs, configuration indexes, divider and history control groups.
// No dependencies.
package tcf_pkg;

	localparam int AXIS_W    = 12;
	localparam int RAW_W     = 15;
	localparam int RAW_SHIFT = 3;
	localparam int CFG_W     = 12;
	localparam int MODE_W    = 4;
	localparam int IDX_W     = 3;

	// shared divider: 24-bit dividend, 12-bit divisor, two quotient bits a cycle
	localparam int DIV_W     = 2 * AXIS_W;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_X_MIN  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_X_MAX  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_Y_MIN  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_Y_MAX  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_X_RES  = 3'd4;
	localparam logic [IDX_W-1:0] CFG_Y_RES  = 3'd5;
	localparam logic [IDX_W-1:0] CFG_MODE   = 3'd6;

	// mode flag bit positions
	localparam int MODE_SWAP  = 0;
	localparam int MODE_INV_X = 1;
	localparam int MODE_INV_Y = 2;
	localparam int MODE_NORM  = 3;

	typedef struct packed {
		logic             pen_down;
		logic [RAW_W-1:0] raw_x_word;
		logic [RAW_W-1:0] raw_y_word;
	} in_t;

	typedef struct packed {
		logic [AXIS_W-1:0] pos_x;
		logic [AXIS_W-1:0] pos_y;
		logic              touch_valid;
	} out_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [AXIS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic push;
		logic clear;
	} hist_ctl_t;

endpackage

[sv/tcf_divider.sv]
// Touch coordinate filter: shared restoring divider, two quotient bits a cycle.
// Depends on tcf_pkg.
module tcf_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  tcf_pkg::div_req_t req,
	output tcf_pkg::div_rsp_t rsp
);

	logic [tcf_pkg::DIV_W-1:0]     dd_q;
	logic [tcf_pkg::AXIS_W-1:0]    rem_q;
	logic [tcf_pkg::AXIS_W-1:0]    dsr_q;
	logic [tcf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [tcf_pkg::DIV_W-1:0]     dd_nx;
	logic [tcf_pkg::AXIS_W-1:0]    rem_nx;

	// one restoring step: bring down the top dividend bit, subtract if it fits
	function automatic logic [tcf_pkg::DIV_W+tcf_pkg::AXIS_W-1:0] div_step(
		input logic [tcf_pkg::DIV_W-1:0]  dd,
		input logic [tcf_pkg::AXIS_W-1:0] rem,
		input logic [tcf_pkg::AXIS_W-1:0] dsr
	);
		logic [tcf_pkg::AXIS_W:0]   t;
		logic                       ge;
		logic [tcf_pkg::AXIS_W:0]   diff;
		logic [tcf_pkg::AXIS_W-1:0] r;
		t    = {rem, dd[tcf_pkg::DIV_W-1]};
		ge   = (t >= {1'b0, dsr});
		diff = t - {1'b0, dsr};
		r    = ge ? diff[tcf_pkg::AXIS_W-1:0] : t[tcf_pkg::AXIS_W-1:0];
		return {dd[tcf_pkg::DIV_W-2:0], ge, r};
	endfunction

	always_comb begin
		logic [tcf_pkg::DIV_W+tcf_pkg::AXIS_W-1:0] s1;
		logic [tcf_pkg::DIV_W+tcf_pkg::AXIS_W-1:0] s2;
		s1 = div_step(dd_q, rem_q, dsr_q);
		s2 = div_step(s1[tcf_pkg::DIV_W+tcf_pkg::AXIS_W-1:tcf_pkg::AXIS_W],
			s1[tcf_pkg::AXIS_W-1:0], dsr_q);
		dd_nx  = s2[tcf_pkg::DIV_W+tcf_pkg::AXIS_W-1:tcf_pkg::AXIS_W];
		rem_nx = s2[tcf_pkg::AXIS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == tcf_pkg::DIV_CNT_W'(tcf_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dd_q  <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dd_q  <= dd_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dd_q;

endmodule

[sv/tcf_history.sv]
// Touch coordinate filter: averaging history with running sums and fill count.
// Depends on tcf_pkg.
module tcf_history #(
	parameter int AVG_DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tcf_pkg::hist_ctl_t                      ctl,
	input  logic [tcf_pkg::AXIS_W-1:0]              new_x,
	input  logic [tcf_pkg::AXIS_W-1:0]              new_y,
	output logic [$clog2(AVG_DEPTH+1)-1:0]          fill,
	output logic [tcf_pkg::AXIS_W+$clog2(AVG_DEPTH+1)-1:0] sum_x,
	output logic [tcf_pkg::AXIS_W+$clog2(AVG_DEPTH+1)-1:0] sum_y
);

	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W  = tcf_pkg::AXIS_W + FILL_W;

	logic [tcf_pkg::AXIS_W-1:0] hist_x_q [AVG_DEPTH];
	logic [tcf_pkg::AXIS_W-1:0] hist_y_q [AVG_DEPTH];
	logic [FILL_W-1:0]          fill_q;
	logic [SUM_W-1:0]           sum_x_q;
	logic [SUM_W-1:0]           sum_y_q;
	logic                       full;

	assign full = (fill_q == FILL_W'(AVG_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			for (int i = 0; i < AVG_DEPTH; i++) begin
				hist_x_q[i] <= '0;
				hist_y_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			fill_q  <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (ctl.push) begin
			for (int i = AVG_DEPTH - 1; i > 0; i--) begin
				hist_x_q[i] <= hist_x_q[i-1];
				hist_y_q[i] <= hist_y_q[i-1];
			end
			hist_x_q[0] <= new_x;
			hist_y_q[0] <= new_y;
			// drop the oldest entry from the sum once the window is full
			if (full) begin
				sum_x_q <= sum_x_q + SUM_W'(new_x) - SUM_W'(hist_x_q[AVG_DEPTH-1]);
				sum_y_q <= sum_y_q + SUM_W'(new_y) - SUM_W'(hist_y_q[AVG_DEPTH-1]);
			end else begin
				sum_x_q <= sum_x_q + SUM_W'(new_x);
				sum_y_q <= sum_y_q + SUM_W'(new_y);
				fill_q  <= fill_q + 1'b1;
			end
		end
	end

	assign fill  = fill_q;
	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;

endmodule

[sv/touch_coordinate_filter_top.sv]
// Touch coordinate filter, top level: configuration registers, sequencer,
// output register. Depends on tcf_pkg, tcf_divider and tcf_history.
//
// Usage
//   Input channel (in_valid/in_ready/in_data) takes one panel sample a beat:
//   pen_down and two raw conversion words. Output channel
//   (out_valid/out_ready/out_data) gives exactly one result beat per sample.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata);
//   write it only while the block is idle. Unknown indexes are ignored.
// Sequencing
//   Pen-up samples and touches with normalisation off: the result is registered
//   and appears in the cycle after the input beat. Normalised touches go through the
//   shared divider, which runs four divisions one after another (scale x,
//   scale y, average x, average y) at two quotient bits a cycle, plus a
//   multiply and the sequencing states. An axis whose maximum is not above
//   its minimum skips its scale division.
//   One sample is in flight at a time; in_ready is low while it is worked on.
// Reset
//   arst_n clears the registers to their defaults, empties the history and
//   zeroes the held coordinates.
// Stalls
//   A result waits in the output register; the next sample is taken while
//   it waits only if it can be delivered in that same edge, otherwise
//   in_ready holds low until out_ready takes the waiting beat.
module touch_coordinate_filter_top #(
	parameter int AVG_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tcf_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tcf_pkg::out_t                     out_data,
	input  logic                              cfg_we,
	input  logic [tcf_pkg::IDX_W-1:0]         cfg_index,
	input  logic [tcf_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int AW     = tcf_pkg::AXIS_W;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W  = AW + FILL_W;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_OFF    = 10'b00_0000_0010,
		S_MUL    = 10'b00_0000_0100,
		S_DSTART = 10'b00_0000_1000,
		S_DWAIT  = 10'b00_0001_0000,
		S_FIN    = 10'b00_0010_0000,
		S_PUSH   = 10'b00_0100_0000,
		S_ASTART = 10'b00_1000_0000,
		S_AWAIT  = 10'b01_0000_0000,
		S_RES    = 10'b10_0000_0000
	} state_t;

	// configuration registers
	logic [AW-1:0]                  x_min_q, x_max_q, y_min_q, y_max_q;
	logic [AW-1:0]                  x_res_q, y_res_q;
	logic [tcf_pkg::MODE_W-1:0]     mode_q;

	// sequencer and datapath
	state_t                         state_q;
	logic                           ax_q;
	logic [AW-1:0]                  val_a_q, val_b_q;
	logic [AW-1:0]                  off_q, span_q;
	logic                           degen_q;
	logic [tcf_pkg::DIV_W-1:0]      prod_q;
	logic [AW-1:0]                  scaled_x_q, scaled_y_q;
	logic [AW-1:0]                  avg_x_q;
	logic [AW-1:0]                  held_x_q, held_y_q;
	logic                           out_valid_q;
	tcf_pkg::out_t                  out_q;

	tcf_pkg::div_req_t              div_req;
	tcf_pkg::div_rsp_t              div_rsp;
	tcf_pkg::hist_ctl_t             hist_ctl;
	logic [FILL_W-1:0]              hist_fill;
	logic [SUM_W-1:0]               hist_sum_x, hist_sum_y;

	logic                           in_fire;
	logic                           out_free;
	logic                           res_load;
	logic [AW-1:0]                  raw_a, raw_b, sw_a, sw_b;
	logic [AW-1:0]                  val_sel, lo_sel, hi_sel, res_sel;
	logic                           inv_sel;
	logic [AW-1:0]                  sat_val, fin_val;
	logic [SUM_W-1:0]               sum_sel;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= AW'(0);
			x_max_q <= AW'(4095);
			y_min_q <= AW'(0);
			y_max_q <= AW'(4095);
			x_res_q <= AW'(320);
			y_res_q <= AW'(240);
			mode_q  <= tcf_pkg::MODE_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcf_pkg::CFG_X_MIN: x_min_q <= cfg_wdata;
				tcf_pkg::CFG_X_MAX: x_max_q <= cfg_wdata;
				tcf_pkg::CFG_Y_MIN: y_min_q <= cfg_wdata;
				tcf_pkg::CFG_Y_MAX: y_max_q <= cfg_wdata;
				tcf_pkg::CFG_X_RES: x_res_q <= cfg_wdata;
				tcf_pkg::CFG_Y_RES: y_res_q <= cfg_wdata;
				tcf_pkg::CFG_MODE:  mode_q  <= cfg_wdata[tcf_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes: the output register must be free, or emptied this edge
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;

	// a result enters the output register: pen-up and pass-through samples at
	// once, normalised touches when the second average is ready
	assign res_load = (in_fire && !(in_data.pen_down && mode_q[tcf_pkg::MODE_NORM]))
		|| ((state_q == S_RES) && out_free);

	// extract the 12-bit readings and apply the optional swap
	assign raw_a = in_data.raw_x_word[tcf_pkg::RAW_W-1:tcf_pkg::RAW_SHIFT];
	assign raw_b = in_data.raw_y_word[tcf_pkg::RAW_W-1:tcf_pkg::RAW_SHIFT];
	assign sw_a  = mode_q[tcf_pkg::MODE_SWAP] ? raw_b : raw_a;
	assign sw_b  = mode_q[tcf_pkg::MODE_SWAP] ? raw_a : raw_b;

	// per-axis operand selection for the shared datapath
	assign val_sel = ax_q ? val_b_q : val_a_q;
	assign lo_sel  = ax_q ? y_min_q : x_min_q;
	assign hi_sel  = ax_q ? y_max_q : x_max_q;
	assign res_sel = ax_q ? y_res_q : x_res_q;
	assign inv_sel = ax_q ? mode_q[tcf_pkg::MODE_INV_Y] : mode_q[tcf_pkg::MODE_INV_X];
	assign sum_sel = ax_q ? hist_sum_y : hist_sum_x;

	// saturate the scaled value at the resolution, then invert if asked
	assign sat_val = (degen_q || (div_rsp.quotient > tcf_pkg::DIV_W'(res_sel)))
		? res_sel : div_rsp.quotient[AW-1:0];
	assign fin_val = inv_sel ? (res_sel - sat_val) : sat_val;

	// shared divider: scale steps divide the product by the span,
	// average steps divide the running sum by the fill count
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = span_q;
		if (state_q == S_DSTART) begin
			div_req.start = !degen_q;
		end else if (state_q == S_ASTART) begin
			div_req.start    = 1'b1;
			div_req.dividend = {{(tcf_pkg::DIV_W-SUM_W){1'b0}}, sum_sel};
			div_req.divisor  = {{(AW-FILL_W){1'b0}}, hist_fill};
		end
	end

	// history control: clear on pen-up, push once both axes are scaled
	always_comb begin
		hist_ctl.clear = in_fire && !in_data.pen_down;
		hist_ctl.push  = (state_q == S_PUSH);
	end

	tcf_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tcf_history #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hist_ctl),
		.new_x  (scaled_x_q),
		.new_y  (scaled_y_q),
		.fill   (hist_fill),
		.sum_x  (hist_sum_x),
		.sum_y  (hist_sum_y)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= 1'b0;
			out_valid_q <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
		end else begin
			// load a new result beat, or drop the waiting one once taken
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					// pen-up samples repeat the held coordinates and stay here
					if (in_fire && in_data.pen_down) begin
						if (mode_q[tcf_pkg::MODE_NORM]) begin
							ax_q    <= 1'b0;
							state_q <= S_OFF;
						end else begin
							// raw readings pass straight through
							held_x_q <= sw_a;
							held_y_q <= sw_b;
						end
					end
				end
				S_OFF:    state_q <= S_MUL;
				S_MUL:    state_q <= S_DSTART;
				S_DSTART: state_q <= degen_q ? S_FIN : S_DWAIT;
				S_DWAIT: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!ax_q) begin
						ax_q    <= 1'b1;
						state_q <= S_OFF;
					end else begin
						ax_q    <= 1'b0;
						state_q <= S_PUSH;
					end
				end
				S_PUSH:   state_q <= S_ASTART;
				S_ASTART: state_q <= S_AWAIT;
				S_AWAIT: begin
					if (div_rsp.done) begin
						if (!ax_q) begin
							ax_q    <= 1'b1;
							state_q <= S_ASTART;
						end else begin
							ax_q    <= 1'b0;
							state_q <= S_RES;
						end
					end
				end
				S_RES: begin
					if (out_free) begin
						held_x_q <= avg_x_q;
						held_y_q <= div_rsp.quotient[AW-1:0];
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_a_q <= sw_a;
			val_b_q <= sw_b;
			if (in_data.pen_down) begin
				out_q <= '{pos_x: sw_a, pos_y: sw_b, touch_valid: 1'b1};
			end else begin
				out_q <= '{pos_x: held_x_q, pos_y: held_y_q, touch_valid: 1'b0};
			end
		end
		if (state_q == S_OFF) begin
			off_q   <= (val_sel > lo_sel) ? (val_sel - lo_sel) : '0;
			span_q  <= hi_sel - lo_sel;
			degen_q <= (hi_sel <= lo_sel);
		end
		if (state_q == S_MUL) begin
			prod_q <= {{AW{1'b0}}, off_q} * {{AW{1'b0}}, res_sel};
		end
		if (state_q == S_FIN) begin
			if (ax_q) begin
				scaled_y_q <= fin_val;
			end else begin
				scaled_x_q <= fin_val;
			end
		end
		if ((state_q == S_AWAIT) && div_rsp.done && !ax_q) begin
			avg_x_q <= div_rsp.quotient[AW-1:0];
		end
		if ((state_q == S_RES) && out_free) begin
			out_q <= '{pos_x: avg_x_q, pos_y: div_rsp.quotient[AW-1:0], touch_valid: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// fill count never runs past the averaging window
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hist_fill <= FILL_W'(AVG_DEPTH))
		else $error("history fill beyond window");

	// a pen-up beat empties the averaging window
	a_penup_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.pen_down |=> hist_fill == '0)
		else $error("fill not cleared after pen-up");

	// the divider is never started on a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> div_req.divisor != '0)
		else $error("divider started with zero divisor");

	// an average is only taken over a non-empty window
	a_avg_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ASTART |-> hist_fill != '0)
		else $error("average over empty history");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the touch coordinate filter: directed and random
// panel samples, a cycle-free predictor and a scoreboard on the result channel.
// Depends on tcf_pkg and touch_coordinate_filter_top.
module testbench;

	localparam int AVG_DEPTH = 4;
	localparam int AW        = tcf_pkg::AXIS_W;
	localparam int MW        = tcf_pkg::MODE_W;
	localparam int IW        = tcf_pkg::IDX_W;
	localparam int CW        = tcf_pkg::CFG_W;
	localparam int RW        = tcf_pkg::RAW_W;
	localparam int DW        = tcf_pkg::DIV_W;

	// out-of-range register index: the block must ignore it
	localparam logic [IW-1:0] CFG_UNUSED = 3'd7;

	// mode flag masks built from the package bit positions
	localparam logic [MW-1:0] M_SWAP  = 4'(1 << tcf_pkg::MODE_SWAP);
	localparam logic [MW-1:0] M_INV_X = 4'(1 << tcf_pkg::MODE_INV_X);
	localparam logic [MW-1:0] M_INV_Y = 4'(1 << tcf_pkg::MODE_INV_Y);
	localparam logic [MW-1:0] M_NORM  = 4'(1 << tcf_pkg::MODE_NORM);

	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 190;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	tcf_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	tcf_pkg::out_t out_data;
	logic          cfg_we = 1'b0;
	logic [IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_wdata = '0;

	touch_coordinate_filter_top #(.AVG_DEPTH(AVG_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Bench copy of the calibration registers, kept in step with every write
	logic [AW-1:0] cal_x_min = 12'd0;
	logic [AW-1:0] cal_x_max = 12'd4095;
	logic [AW-1:0] cal_y_min = 12'd0;
	logic [AW-1:0] cal_y_max = 12'd4095;
	logic [AW-1:0] cal_x_res = 12'd320;
	logic [AW-1:0] cal_y_res = 12'd240;
	logic [MW-1:0] mode_bits = M_NORM;

	// Bench copy of the filter state: averaging window (newest first) and held point
	logic [AW-1:0] hist_x [AVG_DEPTH];
	logic [AW-1:0] hist_y [AVG_DEPTH];
	int            hist_fill = 0;
	logic [AW-1:0] held_x = '0;
	logic [AW-1:0] held_y = '0;

	tcf_pkg::in_t  samples_to_send [$];
	tcf_pkg::out_t expected_positions [$];
	tcf_pkg::out_t want_pos;

	int gap_left = 0;
	int stall_left = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int results_seen = 0;
	int touches_sent = 0;
	int releases_sent = 0;
	int settings_used = 1;

	initial begin
		for (int i = 0; i < AVG_DEPTH; i++) begin
			hist_x[i] = '0;
			hist_y[i] = '0;
		end
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offset, scale with saturation, optional inversion of one axis
	function automatic logic [AW-1:0] scale_reading(logic [AW-1:0] v,
			logic [AW-1:0] lo, logic [AW-1:0] hi,
			logic [AW-1:0] res, logic inv);
		logic [AW-1:0] off;
		logic [DW-1:0] prod;
		logic [DW-1:0] quo;
		logic [AW-1:0] s;
		off = (v > lo) ? v - lo : '0;
		if (hi <= lo) begin
			s = res;
		end else begin
			prod = DW'(off) * DW'(res);
			quo = prod / DW'(hi - lo);
			s = (quo > DW'(res)) ? res : quo[AW-1:0];
		end
		if (inv) begin
			s = res - s;
		end
		return s;
	endfunction

	// Work out the position the block reports for one sample and advance the state
	function automatic tcf_pkg::out_t filter_sample(tcf_pkg::in_t s);
		logic [AW-1:0] rd_a;
		logic [AW-1:0] rd_b;
		logic [AW-1:0] tmp;
		int unsigned   sum_x;
		int unsigned   sum_y;
		tcf_pkg::out_t r;
		if (s.pen_down) begin
			rd_a = AW'(s.raw_x_word >> tcf_pkg::RAW_SHIFT);
			rd_b = AW'(s.raw_y_word >> tcf_pkg::RAW_SHIFT);
			if (mode_bits[tcf_pkg::MODE_SWAP]) begin
				tmp = rd_a;
				rd_a = rd_b;
				rd_b = tmp;
			end
			if (mode_bits[tcf_pkg::MODE_NORM]) begin
				rd_a = scale_reading(rd_a, cal_x_min, cal_x_max, cal_x_res,
					mode_bits[tcf_pkg::MODE_INV_X]);
				rd_b = scale_reading(rd_b, cal_y_min, cal_y_max, cal_y_res,
					mode_bits[tcf_pkg::MODE_INV_Y]);
				for (int i = AVG_DEPTH - 1; i > 0; i--) begin
					hist_x[i] = hist_x[i-1];
					hist_y[i] = hist_y[i-1];
				end
				hist_x[0] = rd_a;
				hist_y[0] = rd_b;
				if (hist_fill < AVG_DEPTH) begin
					hist_fill++;
				end
				sum_x = 0;
				sum_y = 0;
				for (int i = 0; i < hist_fill; i++) begin
					sum_x += hist_x[i];
					sum_y += hist_y[i];
				end
				rd_a = AW'(sum_x / hist_fill);
				rd_b = AW'(sum_y / hist_fill);
			end
			held_x = rd_a;
			held_y = rd_b;
		end else begin
			// pen lifted: repeat the last point and restart the average
			hist_fill = 0;
		end
		r.pos_x = held_x;
		r.pos_y = held_y;
		r.touch_valid = s.pen_down;
		return r;
	endfunction

	// Driver: present one sample beat at a time, hold it until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_positions.push_back(filter_sample(in_data));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (samples_to_send.size() == 0) begin
					in_valid <= 1'b0;
				end else if ($urandom_range(99) < gap_pct) begin
					gap_left = $urandom_range(0, 17);
					in_valid <= 1'b0;
				end else begin
					in_data <= samples_to_send.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	// Monitor: check each result beat against the oldest prediction, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_positions.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got x=%0d y=%0d valid=%0b",
						$time, out_data.pos_x, out_data.pos_y, out_data.touch_valid);
				end else begin
					want_pos = expected_positions.pop_front();
					if (out_data.pos_x !== want_pos.pos_x ||
							out_data.pos_y !== want_pos.pos_y ||
							out_data.touch_valid !== want_pos.touch_valid) begin
						errors++;
						$display("%0t: result mismatch, expected x=%0d y=%0d valid=%0b,",
							$time, want_pos.pos_x, want_pos.pos_y, want_pos.touch_valid,
							" got x=%0d y=%0d valid=%0b",
							out_data.pos_x, out_data.pos_y, out_data.touch_valid);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic queue_sample(logic pen, logic [RW-1:0] xw, logic [RW-1:0] yw);
		tcf_pkg::in_t s;
		s.pen_down = pen;
		s.raw_x_word = xw;
		s.raw_y_word = yw;
		samples_to_send.push_back(s);
		if (pen) begin
			touches_sent++;
		end else begin
			releases_sent++;
		end
	endtask

	// Wait until every queued sample has gone in and every result has come back
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (samples_to_send.size() != 0 || in_valid || expected_positions.size() != 0);
	endtask

	task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tcf_pkg::CFG_X_MIN: cal_x_min = val;
			tcf_pkg::CFG_X_MAX: cal_x_max = val;
			tcf_pkg::CFG_Y_MIN: cal_y_min = val;
			tcf_pkg::CFG_Y_MAX: cal_y_max = val;
			tcf_pkg::CFG_X_RES: cal_x_res = val;
			tcf_pkg::CFG_Y_RES: cal_y_res = val;
			tcf_pkg::CFG_MODE:  mode_bits = val[MW-1:0];
			default: ;
		endcase
	endtask

	// Drain first: registers may only change while the block is idle
	task automatic set_calibration(int x_lo, int x_hi, int y_lo, int y_hi, int x_res,
			int y_res, logic [MW-1:0] mode);
		wait_drained();
		write_reg(tcf_pkg::CFG_X_MIN, CW'(x_lo));
		write_reg(tcf_pkg::CFG_X_MAX, CW'(x_hi));
		write_reg(tcf_pkg::CFG_Y_MIN, CW'(y_lo));
		write_reg(tcf_pkg::CFG_Y_MAX, CW'(y_hi));
		write_reg(tcf_pkg::CFG_X_RES, CW'(x_res));
		write_reg(tcf_pkg::CFG_Y_RES, CW'(y_res));
		// junk in the upper bits of the mode word must be dropped
		write_reg(tcf_pkg::CFG_MODE, {8'($urandom), mode});
		settings_used++;
		@(negedge clk);
	endtask

	// Favour readings on and next to the calibration edges
	function automatic logic [AW-1:0] pick_reading();
		case ($urandom_range(0, 11))
			0: return cal_x_min;
			1: return cal_x_max;
			2: return cal_y_min;
			3: return cal_y_max;
			4: return cal_x_min + 12'd1;
			5: return cal_y_max - 12'd1;
			6: return 12'd0;
			7: return 12'd4095;
			default: return AW'($urandom);
		endcase
	endfunction

	initial begin
		int lo_x;
		int lo_y;
		int hi_x;
		int hi_y;
		int res_x;
		int res_y;
		int strokes;
		int queued;
		logic [MW-1:0] mode;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gap_pct = 20;
		stall_pct = 20;

		// Reset settings: pen-up before any touch, raw extremes, low bits that must drop
		queue_sample(1'b0, 15'h0000, 15'h0000);
		queue_sample(1'b1, 15'h0000, 15'h0000);
		queue_sample(1'b1, 15'h7FFF, 15'h7FFF);
		queue_sample(1'b1, 15'h0007, 15'h7FF8);
		queue_sample(1'b1, 15'h7FF8, 15'h0007);
		queue_sample(1'b1, 15'h4000, 15'h2AAA);
		queue_sample(1'b0, 15'h5555, 15'h2AAA);
		queue_sample(1'b1, 15'h7FFF, 15'h0000);
		queue_sample(1'b0, 15'h7FFF, 15'h7FFF);

		// Normalisation off with swap: invert bits must have no effect
		set_calibration(100, 200, 300, 400, 50, 60, M_SWAP | M_INV_X | M_INV_Y);
		queue_sample(1'b1, 15'h7FFF, 15'h0000);
		queue_sample(1'b1, 15'h1238, 15'h7000);
		queue_sample(1'b0, 15'h0000, 15'h7FFF);

		// Full-range register extremes, all flags set
		set_calibration(0, 4095, 4094, 4095, 4095, 1, M_SWAP | M_INV_X | M_INV_Y | M_NORM);
		queue_sample(1'b1, 15'h0000, 15'h0000);
		queue_sample(1'b1, 15'h7FFF, 15'h7FFF);
		queue_sample(1'b0, 15'h0000, 15'h0000);

		// Scale overflow on x, equal bounds on y, both inverted
		set_calibration(0, 1, 3000, 3000, 4095, 77, M_INV_X | M_INV_Y | M_NORM);
		queue_sample(1'b1, 15'h7FFF, 15'h7FFF);
		queue_sample(1'b1, 15'h0000, 15'h0000);
		queue_sample(1'b1, 15'h0008, 15'h0008);

		// Maximum below minimum on x, y inverted
		set_calibration(4094, 1, 100, 200, 4095, 4095, M_INV_Y | M_NORM);
		queue_sample(1'b1, 15'h7FFF, 15'h0320);
		queue_sample(1'b1, 15'h0000, 15'h0648);

		// A write to an index that does not exist must change nothing
		wait_drained();
		write_reg(CFG_UNUSED, CW'($urandom));

		for (int ph = 0; ph < PHASES; ph++) begin
			lo_x = $urandom_range(0, 4094);
			lo_y = $urandom_range(0, 4094);
			hi_x = ($urandom_range(7) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(lo_x + 1, 4095);
			hi_y = ($urandom_range(7) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(lo_y + 1, 4095);
			res_x = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4095);
			res_y = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4095);
			mode = MW'($urandom_range(0, 15));
			if ($urandom_range(3) != 0) begin
				mode = mode | M_NORM;
			end
			set_calibration(lo_x, hi_x, lo_y, hi_y, res_x, res_y, mode);

			// no idling at all in the closing phase
			if (ph == PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = 10 * $urandom_range(0, 6);
				stall_pct = 10 * $urandom_range(0, 6);
			end

			// Strokes of touches closed by one or more pen-ups; empty strokes add noise
			queued = 0;
			while (queued < ITEMS_PER_PHASE) begin
				strokes = $urandom_range(0, 10);
				repeat (strokes) begin
					queue_sample(1'b1, {pick_reading(), 3'($urandom)},
						{pick_reading(), 3'($urandom)});
				end
				queued += strokes;
				repeat ($urandom_range(1, 3)) begin
					queue_sample(1'b0, RW'($urandom), RW'($urandom));
					queued++;
				end
			end
		end

		wait_drained();
		// watch for stray beats after the last expected one
		repeat (80) @(posedge clk);
		if (expected_positions.size() != 0) begin
			errors++;
		end

		$display("Checked %0d results: %0d touch and %0d pen-up samples", results_seen,
			touches_sent, releases_sent);
		$display("Calibration settings exercised: %0d, failures: %0d", settings_used, errors);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(8 * 3000000);
		$display("Timeout: %0d results still outstanding", expected_positions.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
